// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// ============================================================================
// assertion macros
// shared property shapes, clocked on clk, off while rst_n is low
// ============================================================================

// consequent holds in the same cycle as the antecedent
`define NLSD_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define NLSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/nlsd_pkg.sv
// ============================================================================
// nlsd_pkg
// types and constants of the node list stream decoder
// ============================================================================
package nlsd_pkg;

    localparam int MAX_NODES_DEF   = 2048;
    localparam int COUNT_W         = 11;
    localparam int FLAGS_W         = 16;
    localparam int BYTE_W          = 8;
    localparam int NIB_W           = 4;
    localparam int LOW_W           = 32;
    localparam int ID_W            = 35;
    localparam int UPPER_SHIFT     = 31;
    localparam int FLAG_UNIFORM    = 13;
    localparam int FLAG_CLOSED     = 14;
    localparam int FLAG_COMPRESSED = 15;
    localparam int RES_DEPTH       = 4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NIB,
        PH_RAW,
        PH_SIZE,
        PH_FIRST,
        PH_CTRL,
        PH_VBYTE
    } phase_t;

    typedef struct packed {
        logic               req_type;
        logic [FLAGS_W-1:0] way_flags;
        logic [BYTE_W-1:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    node_id;
        logic [COUNT_W-1:0] node_position;
        logic               is_repeat;
        logic               last_node;
    } out_item_t;

endpackage

// File: design/nlsd_stream_if.sv
// ============================================================================
// nlsd_stream_if
// valid/ready stream channel carrying one payload per transaction
// ============================================================================
interface nlsd_stream_if #(
    parameter type data_t = logic
);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// File: design/node_list_stream_decoder_core.sv
// ============================================================================
// node_list_stream_decoder_core
// decodes encoded node lists from a byte stream into 35-bit node ids
// ============================================================================
// byte_in takes one transaction per ready cycle: a start (req_type low) with the
// flag word, or one data byte (req_type high). node_out gives one result per
// transaction: node id, position, repeat mark and last mark.
// the upper nibbles and the control bytes live in two synchronous memories;
// a finished id passes the result stage register and the result queue before it leaves node_out.
// throughput is one byte per cycle while byte_in.ready is high, limited by the single decode pass per
// byte; a closed list adds its repeat result in the same cycle as its last.
// results wait in a 4-entry queue; byte_in.ready falls when the queue plus
// the result in flight leaves no room for two more, so a stalled receiver
// holds the input back without losing or repeating a result.
// reset returns the decoder to idle and empties the queue; the memories need
// no clearing pass since every entry is written before a list reads it.
// data bytes with no list open are dropped; a start abandons an open list.
// ============================================================================
`include "assert_macros.svh"

module node_list_stream_decoder_core #(
    parameter int MAX_NODES = nlsd_pkg::MAX_NODES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    nlsd_stream_if.sink   byte_in,
    nlsd_stream_if.source node_out
);

    localparam int COUNT_W    = nlsd_pkg::COUNT_W;
    localparam int LOW_W      = nlsd_pkg::LOW_W;
    localparam int ID_W       = nlsd_pkg::ID_W;
    localparam int NIB_W      = nlsd_pkg::NIB_W;
    localparam int BYTE_W     = nlsd_pkg::BYTE_W;
    localparam int NIB_DEPTH  = (MAX_NODES + 1) / 2;
    localparam int NIB_AW     = (NIB_DEPTH > 1) ? $clog2(NIB_DEPTH) : 1;
    localparam int CTRL_DEPTH = (MAX_NODES + 3) / 4;
    localparam int CTRL_AW    = (CTRL_DEPTH > 1) ? $clog2(CTRL_DEPTH) : 1;
    localparam int RES_DEPTH  = nlsd_pkg::RES_DEPTH;
    localparam int FIFO_AW    = $clog2(RES_DEPTH);
    localparam int FIFO_CW    = $clog2(RES_DEPTH + 1);
    localparam logic [COUNT_W:0] MAX_CNT = (COUNT_W + 1)'(MAX_NODES);

    typedef struct packed {
        logic               last;
        logic               closed;
        logic [COUNT_W-1:0] idx;
        logic [COUNT_W-1:0] cnt;
        logic               nib_hi;
        logic [LOW_W-1:0]   low_word;
    } s1_t;

    nlsd_pkg::in_item_t  in_item;
    logic                in_acc;
    logic                is_start;
    logic                is_data;

    nlsd_pkg::phase_t    phase_reg, phase_next;
    logic                uniform_reg, uniform_next;
    logic                closed_reg, closed_next;
    logic                compressed_reg, compressed_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [COUNT_W-2:0]  nctrl_reg, nctrl_next;
    logic [COUNT_W-1:0]  item_cnt_reg, item_cnt_next;
    logic [1:0]          byte_cnt_reg, byte_cnt_next;
    logic [23:0]         asm_reg, asm_next;
    logic [LOW_W-1:0]    prev_reg, prev_next;

    logic [LOW_W-1:0]    word;
    logic [COUNT_W:0]    flag_cnt;
    logic [COUNT_W-1:0]  start_cnt;
    logic [COUNT_W:0]    start_cnt_p2;
    logic [COUNT_W:0]    idx_p1;
    logic [COUNT_W:0]    idx_p2;
    logic                last_hit;
    logic [COUNT_W-1:0]  item_p1;
    logic [COUNT_W-1:0]  val_idx;
    logic [BYTE_W-1:0]   ctrl_shift;
    logic [1:0]          code;
    logic [LOW_W-1:0]    zz;
    logic [LOW_W-1:0]    delta_sum;
    logic                emit;
    logic [LOW_W-1:0]    emit_low;
    logic                nib_we;
    logic                ctrl_we;

    logic [BYTE_W-1:0]   nib_mem [NIB_DEPTH];
    logic [BYTE_W-1:0]   ctrl_mem [CTRL_DEPTH];
    logic [BYTE_W-1:0]   nib_rd_reg;
    logic [BYTE_W-1:0]   ctrl_rd_reg;
    logic [NIB_AW-1:0]   nib_waddr;
    logic [NIB_AW-1:0]   nib_raddr;
    logic [CTRL_AW-1:0]  ctrl_waddr;
    logic [CTRL_AW-1:0]  ctrl_raddr;
    logic [COUNT_W-1:0]  next_val_idx;

    logic                s1_valid_reg;
    s1_t                 s1_reg;
    logic [NIB_W-1:0]    s1_nib;
    logic [ID_W-1:0]     s1_id;
    logic [ID_W-1:0]     first_id;
    logic [ID_W-1:0]     first_node_reg;
    logic                s1_rep;
    logic [1:0]          s1_n;
    nlsd_pkg::out_item_t res_a;
    nlsd_pkg::out_item_t res_b;

    nlsd_pkg::out_item_t fifo_mem [RES_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_CW-1:0]  fifo_cnt_reg;
    logic                pop;

    assign in_item  = byte_in.data;
    assign in_acc   = byte_in.valid && byte_in.ready;
    assign is_start = in_acc && (in_item.req_type == nlsd_pkg::REQ_START);
    assign is_data  = in_acc && (in_item.req_type == nlsd_pkg::REQ_DATA);

    // decode of one byte against the list state
    always_comb
    begin
        phase_next      = phase_reg;
        uniform_next    = uniform_reg;
        closed_next     = closed_reg;
        compressed_next = compressed_reg;
        cnt_next        = cnt_reg;
        nctrl_next      = nctrl_reg;
        item_cnt_next   = item_cnt_reg;
        byte_cnt_next   = byte_cnt_reg;
        asm_next        = asm_reg;
        prev_next       = prev_reg;
        emit            = 1'b0;
        emit_low        = '0;
        nib_we          = 1'b0;
        ctrl_we         = 1'b0;

        word = {8'b0, asm_reg}
             | (LOW_W'(in_item.data_byte) << {byte_cnt_reg, 3'b000});
        flag_cnt     = {1'b0, in_item.way_flags[COUNT_W-1:0]};
        start_cnt    = (flag_cnt > MAX_CNT) ? MAX_CNT[COUNT_W-1:0]
                                            : flag_cnt[COUNT_W-1:0];
        start_cnt_p2 = {1'b0, start_cnt} + (COUNT_W + 1)'(2);
        idx_p1       = {1'b0, item_cnt_reg} + (COUNT_W + 1)'(1);
        idx_p2       = {1'b0, item_cnt_reg} + (COUNT_W + 1)'(2);
        last_hit     = idx_p1 >= {1'b0, cnt_reg};
        item_p1      = idx_p1[COUNT_W-1:0];
        val_idx      = item_cnt_reg - COUNT_W'(1);
        ctrl_shift   = ctrl_rd_reg >> {val_idx[1:0], 1'b0};
        code         = ctrl_shift[1:0];
        zz           = word[0] ? ~(word >> 1) : (word >> 1);
        delta_sum    = prev_reg + zz;

        if (is_start)
        begin
            uniform_next    = in_item.way_flags[nlsd_pkg::FLAG_UNIFORM];
            closed_next     = in_item.way_flags[nlsd_pkg::FLAG_CLOSED];
            compressed_next = in_item.way_flags[nlsd_pkg::FLAG_COMPRESSED];
            cnt_next        = start_cnt;
            nctrl_next      = start_cnt_p2[COUNT_W:2];
            item_cnt_next   = '0;
            byte_cnt_next   = '0;
            asm_next        = '0;
            prev_next       = '0;
            phase_next      = (start_cnt == '0) ? nlsd_pkg::PH_IDLE : nlsd_pkg::PH_NIB;
        end
        else if (is_data)
        begin
            unique case (phase_reg)
                nlsd_pkg::PH_IDLE:
                begin
                    phase_next = nlsd_pkg::PH_IDLE;
                end
                nlsd_pkg::PH_NIB:
                begin
                    nib_we = 1'b1;
                    if (uniform_reg || (idx_p2 >= {1'b0, cnt_reg}))
                    begin
                        item_cnt_next = '0;
                        byte_cnt_next = '0;
                        asm_next      = '0;
                        phase_next    = compressed_reg ? nlsd_pkg::PH_SIZE
                                                       : nlsd_pkg::PH_RAW;
                    end
                    else
                    begin
                        item_cnt_next = idx_p2[COUNT_W-1:0];
                    end
                end
                nlsd_pkg::PH_RAW:
                begin
                    if (byte_cnt_reg == 2'd3)
                    begin
                        byte_cnt_next = '0;
                        asm_next      = '0;
                        emit          = 1'b1;
                        emit_low      = word;
                        item_cnt_next = item_p1;
                        if (last_hit)
                        begin
                            phase_next = nlsd_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                        asm_next      = word[23:0];
                    end
                end
                nlsd_pkg::PH_SIZE:
                begin
                    if (byte_cnt_reg == 2'd0)
                    begin
                        byte_cnt_next = 2'd1;
                    end
                    else
                    begin
                        byte_cnt_next = '0;
                        asm_next      = '0;
                        phase_next    = nlsd_pkg::PH_FIRST;
                    end
                end
                nlsd_pkg::PH_FIRST:
                begin
                    if (byte_cnt_reg == 2'd3)
                    begin
                        prev_next     = word;
                        asm_next      = '0;
                        byte_cnt_next = '0;
                        item_cnt_next = '0;
                        emit          = 1'b1;
                        emit_low      = word;
                        phase_next    = last_hit ? nlsd_pkg::PH_IDLE : nlsd_pkg::PH_CTRL;
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                        asm_next      = word[23:0];
                    end
                end
                nlsd_pkg::PH_CTRL:
                begin
                    ctrl_we = 1'b1;
                    if (item_p1 >= {1'b0, nctrl_reg})
                    begin
                        item_cnt_next = COUNT_W'(1);
                        byte_cnt_next = '0;
                        asm_next      = '0;
                        phase_next    = nlsd_pkg::PH_VBYTE;
                    end
                    else
                    begin
                        item_cnt_next = item_p1;
                    end
                end
                nlsd_pkg::PH_VBYTE:
                begin
                    if (byte_cnt_reg >= code)
                    begin
                        byte_cnt_next = '0;
                        asm_next      = '0;
                        prev_next     = delta_sum;
                        emit          = 1'b1;
                        emit_low      = delta_sum;
                        item_cnt_next = item_p1;
                        if (last_hit)
                        begin
                            phase_next = nlsd_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                        asm_next      = word[23:0];
                    end
                end
                default:
                begin
                    phase_next = nlsd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= nlsd_pkg::PH_IDLE;
            uniform_reg    <= 1'b0;
            closed_reg     <= 1'b0;
            compressed_reg <= 1'b0;
            cnt_reg        <= '0;
            nctrl_reg      <= '0;
            item_cnt_reg   <= '0;
            byte_cnt_reg   <= '0;
            asm_reg        <= '0;
            prev_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            uniform_reg    <= uniform_next;
            closed_reg     <= closed_next;
            compressed_reg <= compressed_next;
            cnt_reg        <= cnt_next;
            nctrl_reg      <= nctrl_next;
            item_cnt_reg   <= item_cnt_next;
            byte_cnt_reg   <= byte_cnt_next;
            asm_reg        <= asm_next;
            prev_reg       <= prev_next;
        end
    end

    // upper nibble memory, two nibbles per entry
    assign nib_waddr = item_cnt_reg[NIB_AW:1];
    assign nib_raddr = uniform_reg ? '0 : item_cnt_reg[NIB_AW:1];

    always_ff @(posedge clk)
    begin
        if (nib_we)
        begin
            nib_mem[nib_waddr] <= in_item.data_byte;
        end
        nib_rd_reg <= nib_mem[nib_raddr];
    end

    // control byte memory, read ahead for the next value's code
    assign next_val_idx = item_cnt_next - COUNT_W'(1);
    assign ctrl_waddr   = item_cnt_reg[CTRL_AW-1:0];
    assign ctrl_raddr   = next_val_idx[CTRL_AW+1:2];

    always_ff @(posedge clk)
    begin
        if (ctrl_we)
        begin
            ctrl_mem[ctrl_waddr] <= in_item.data_byte;
        end
        if (ctrl_we && (ctrl_waddr == ctrl_raddr))
        begin
            ctrl_rd_reg <= in_item.data_byte;
        end
        else
        begin
            ctrl_rd_reg <= ctrl_mem[ctrl_raddr];
        end
    end

    // result stage: join upper nibble and low word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_reg.last     <= last_hit;
            s1_reg.closed   <= closed_reg;
            s1_reg.idx      <= item_cnt_reg;
            s1_reg.cnt      <= cnt_reg;
            s1_reg.nib_hi   <= !uniform_reg && item_cnt_reg[0];
            s1_reg.low_word <= emit_low;
        end
        if (s1_valid_reg && (s1_reg.idx == '0))
        begin
            first_node_reg <= s1_id;
        end
    end

    always_comb
    begin
        s1_nib   = s1_reg.nib_hi ? nib_rd_reg[7:4] : nib_rd_reg[3:0];
        s1_id    = {s1_nib, {nlsd_pkg::UPPER_SHIFT{1'b0}}} | ID_W'(s1_reg.low_word);
        first_id = (s1_reg.idx == '0) ? s1_id : first_node_reg;
        s1_rep   = s1_valid_reg && s1_reg.last && s1_reg.closed;
        s1_n     = s1_valid_reg ? (s1_rep ? 2'd2 : 2'd1) : 2'd0;

        res_a.node_id       = s1_id;
        res_a.node_position = s1_reg.idx;
        res_a.is_repeat     = 1'b0;
        res_a.last_node     = s1_reg.last && !s1_reg.closed;

        res_b.node_id       = first_id;
        res_b.node_position = s1_reg.cnt;
        res_b.is_repeat     = 1'b1;
        res_b.last_node     = 1'b1;
    end

    // result queue, up to two pushes and one pop per cycle
    assign pop = node_out.valid && node_out.ready;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fifo_mem[wr_ptr_reg] <= res_a;
        end
        if (s1_rep)
        begin
            fifo_mem[wr_ptr_reg + FIFO_AW'(1)] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_reg + FIFO_AW'(s1_n);
            rd_ptr_reg   <= rd_ptr_reg + FIFO_AW'(pop);
            fifo_cnt_reg <= fifo_cnt_reg + FIFO_CW'(s1_n) - FIFO_CW'(pop);
        end
    end

    assign node_out.valid = (fifo_cnt_reg != '0);
    assign node_out.data  = fifo_mem[rd_ptr_reg];
    assign byte_in.ready  = ({1'b0, fifo_cnt_reg} + (FIFO_CW + 1)'(s1_n))
                            <= (FIFO_CW + 1)'(RES_DEPTH - 2);

    `NLSD_ASSERT_HOLDS(a_queue_no_overflow, s1_valid_reg,
        ({1'b0, fifo_cnt_reg} + (FIFO_CW + 1)'(s1_n)) <= (FIFO_CW + 1)'(RES_DEPTH),
        "result queue overflow")
    `NLSD_ASSERT_HOLDS(a_repeat_is_last, node_out.valid && node_out.data.is_repeat,
        node_out.data.last_node, "repeat result not marked last")
    `NLSD_ASSERT_NEXT(a_start_no_result, is_start, !s1_valid_reg,
        "start transaction produced a result")
    `NLSD_ASSERT_HOLDS(a_vbyte_index, phase_reg == nlsd_pkg::PH_VBYTE,
        item_cnt_reg != '0, "value index zero in vbyte body")

endmodule

// File: tb/tb_node_list_stream_decoder_core.sv
// ============================================================================
// tb_node_list_stream_decoder_core
// self-checking bench for the node list stream decoder: a short table of
// hand-picked transactions, then random raw and stream vbyte lists with
// broken lists and noise mixed in. every accepted transaction runs through
// a local decoder model, and each result on node_out is compared with the
// oldest predicted node. both sides idle at random, and the output side
// stalls once for a long stretch.
// ============================================================================
module tb_node_list_stream_decoder_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FLAGS_W         = nlsd_pkg::FLAGS_W;
    localparam int BYTE_W          = nlsd_pkg::BYTE_W;
    localparam int COUNT_W         = nlsd_pkg::COUNT_W;
    localparam int NIB_W           = nlsd_pkg::NIB_W;
    localparam int LOW_W           = nlsd_pkg::LOW_W;
    localparam int ID_W            = nlsd_pkg::ID_W;
    localparam int FLAG_UNIFORM    = nlsd_pkg::FLAG_UNIFORM;
    localparam int FLAG_CLOSED     = nlsd_pkg::FLAG_CLOSED;
    localparam int FLAG_COMPRESSED = nlsd_pkg::FLAG_COMPRESSED;
    localparam logic REQ_START     = nlsd_pkg::REQ_START;
    localparam logic REQ_DATA      = nlsd_pkg::REQ_DATA;

    localparam int NODES        = nlsd_pkg::MAX_NODES_DEF;
    localparam int ITEMS        = 500;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT        = 400000;

    typedef nlsd_pkg::in_item_t  in_item_t;
    typedef nlsd_pkg::out_item_t out_item_t;

    typedef struct {
        logic               req;
        logic [FLAGS_W-1:0] flags;
        logic [BYTE_W-1:0]  dbyte;
        int                 n_typed;
        out_item_t          t0;
        out_item_t          t1;
    } stim_row_t;

    logic clk;
    logic rst_n;

    nlsd_stream_if #(.data_t(in_item_t))  byte_in ();
    nlsd_stream_if #(.data_t(out_item_t)) node_out ();

    node_list_stream_decoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .node_out (node_out)
    );

    // decoder model state
    nlsd_pkg::phase_t   dec_phase;
    logic [FLAGS_W-1:0] list_flags;
    logic [COUNT_W-1:0] node_idx;
    logic [NIB_W-1:0]   upper_mem [NODES];
    logic [BYTE_W-1:0]  code_mem [NODES/4];
    logic [LOW_W-1:0]   word_acc;
    logic [1:0]         byte_cnt;
    logic [LOW_W-1:0]   prev_low;
    logic [ID_W-1:0]    first_id;
    out_item_t          new_nodes [2];
    bit                 byte_dropped;

    out_item_t pending_nodes [$];
    stim_row_t dir_rows [25];

    int  n_errors;
    int  n_checked;
    int  n_used;
    int  n_lists;
    int  n_holds;
    int  cycle_cnt;
    bit  hold_req;
    bit  sink_quiet;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("%0t: timeout, %0d nodes still pending", $time, pending_nodes.size());
            $display("tb_node_list_stream_decoder_core failed");
            $finish;
        end
    end

    function automatic int list_len();
        return int'(list_flags[COUNT_W-1:0]);
    endfunction

    function automatic int emit_node(input int idx, input logic [LOW_W-1:0] lw);
        int              cnt;
        logic [NIB_W-1:0] nib;
        logic [ID_W-1:0] id;
        bit              last;
        bit              closed;
        cnt = list_len();
        nib = list_flags[FLAG_UNIFORM] ? upper_mem[0] : upper_mem[idx];
        id = {nib, 31'b0} | {3'b0, lw};
        last = idx + 1 >= cnt;
        closed = list_flags[FLAG_CLOSED];
        if (idx == 0)
            first_id = id;
        new_nodes[0] = '{id, COUNT_W'(idx), 1'b0, last && !closed};
        if (!last)
            return 1;
        dec_phase = nlsd_pkg::PH_IDLE;
        if (!closed)
            return 1;
        new_nodes[1] = '{first_id, COUNT_W'(cnt), 1'b1, 1'b1};
        return 2;
    endfunction

    // little-endian word assembly, true once byte number need has arrived
    function automatic bit take_byte(input logic [BYTE_W-1:0] b, input int need);
        word_acc = word_acc | ({24'b0, b} << (8 * byte_cnt));
        if (int'(byte_cnt) >= need)
        begin
            byte_cnt = 2'd0;
            return 1'b1;
        end
        byte_cnt = byte_cnt + 2'd1;
        return 1'b0;
    endfunction

    function automatic int decode_byte(input in_item_t it);
        int               cnt;
        int               i;
        int               v;
        logic [LOW_W-1:0] a;
        logic [LOW_W-1:0] z;
        logic [1:0]       code;
        bit               done;
        byte_dropped = 1'b0;
        if (it.req_type == REQ_START)
        begin
            list_flags = it.way_flags;
            node_idx = '0;
            word_acc = '0;
            byte_cnt = '0;
            prev_low = '0;
            dec_phase = (list_len() == 0) ? nlsd_pkg::PH_IDLE : nlsd_pkg::PH_NIB;
            return 0;
        end
        if (dec_phase == nlsd_pkg::PH_IDLE)
        begin
            byte_dropped = 1'b1;
            return 0;
        end
        cnt = list_len();
        case (dec_phase)
            nlsd_pkg::PH_NIB:
            begin
                done = 1'b1;
                if (list_flags[FLAG_UNIFORM])
                    upper_mem[0] = it.data_byte[3:0];
                else
                begin
                    i = int'(node_idx);
                    upper_mem[i] = it.data_byte[3:0];
                    if (i + 1 < cnt)
                        upper_mem[i+1] = it.data_byte[7:4];
                    if (i + 2 < cnt)
                    begin
                        node_idx = COUNT_W'(i + 2);
                        done = 1'b0;
                    end
                end
                if (done)
                begin
                    node_idx = '0;
                    byte_cnt = '0;
                    word_acc = '0;
                    dec_phase = list_flags[FLAG_COMPRESSED] ? nlsd_pkg::PH_SIZE
                                                            : nlsd_pkg::PH_RAW;
                end
                return 0;
            end
            nlsd_pkg::PH_RAW:
            begin
                if (!take_byte(it.data_byte, 3))
                    return 0;
                a = word_acc;
                word_acc = '0;
                i = int'(node_idx);
                node_idx = node_idx + 1'b1;
                return emit_node(i, a);
            end
            nlsd_pkg::PH_SIZE:
            begin
                if (byte_cnt == 2'd0)
                    byte_cnt = 2'd1;
                else
                begin
                    byte_cnt = '0;
                    word_acc = '0;
                    dec_phase = nlsd_pkg::PH_FIRST;
                end
                return 0;
            end
            nlsd_pkg::PH_FIRST:
            begin
                if (!take_byte(it.data_byte, 3))
                    return 0;
                prev_low = word_acc;
                word_acc = '0;
                node_idx = '0;
                dec_phase = nlsd_pkg::PH_CTRL;
                return emit_node(0, prev_low);
            end
            nlsd_pkg::PH_CTRL:
            begin
                if (int'(node_idx) < NODES / 4)
                    code_mem[node_idx] = it.data_byte;
                node_idx = node_idx + 1'b1;
                if (int'(node_idx) >= (cnt + 2) / 4)
                begin
                    node_idx = COUNT_W'(1);
                    byte_cnt = '0;
                    word_acc = '0;
                    dec_phase = nlsd_pkg::PH_VBYTE;
                end
                return 0;
            end
            nlsd_pkg::PH_VBYTE:
            begin
                v = (int'(node_idx) + NODES - 1) % NODES;
                code = code_mem[v / 4][2 * (v % 4) +: 2];
                if (!take_byte(it.data_byte, int'(code)))
                    return 0;
                a = word_acc;
                word_acc = '0;
                z = (a >> 1) ^ {LOW_W{a[0]}};
                prev_low = prev_low + z;
                i = int'(node_idx);
                node_idx = node_idx + 1'b1;
                return emit_node(i, prev_low);
            end
            default:
            begin
                dec_phase = nlsd_pkg::PH_IDLE;
                return 0;
            end
        endcase
        return 0;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_item_t data_of(input logic [BYTE_W-1:0] b);
        in_item_t it;
        it.req_type = REQ_DATA;
        it.way_flags = 16'($urandom);
        it.data_byte = b;
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input bit quiet, input int n_typed,
                             input out_item_t t0, input out_item_t t1);
        int gap;
        int n;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            byte_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_in.valid <= 1'b1;
        byte_in.data <= it;
        do
            @(negedge clk);
        while (!byte_in.ready);
        n = decode_byte(it);
        if (!byte_dropped)
            n_used++;
        if (n_typed > 0)
        begin
            pending_nodes = {pending_nodes, t0};
            if (n_typed > 1)
                pending_nodes = {pending_nodes, t1};
        end
        else
        begin
            for (int k = 0; k < n; k++)
                pending_nodes = {pending_nodes, new_nodes[k]};
        end
        @(posedge clk);
    endtask

    task automatic send_list(input int forced, input bit quiet);
        in_item_t           body [$];
        logic [BYTE_W-1:0]  codes [$];
        in_item_t           head;
        int                 cnt;
        int                 nb;
        int                 k;
        int                 v;
        bit                 uni;
        bit                 cmp;
        if (forced > 0)
            cnt = forced;
        else if ($urandom_range(0, 9) == 0)
            cnt = $urandom_range(13, 48);
        else
            cnt = $urandom_range(1, 8);
        uni = 1'($urandom_range(0, 1));
        cmp = 1'($urandom_range(0, 1));
        head.req_type = REQ_START;
        head.way_flags = {cmp, 1'($urandom), uni, 2'($urandom), COUNT_W'(cnt)};
        head.data_byte = rand_byte();
        body = {body, head};
        nb = uni ? 1 : (cnt + 1) / 2;
        for (k = 0; k < nb; k++)
            body = {body, data_of(rand_byte())};
        if (!cmp)
        begin
            for (k = 0; k < 4 * cnt; k++)
                body = {body, data_of(rand_byte())};
        end
        else
        begin
            // size, first word, control bytes, then the value bytes
            for (k = 0; k < 6; k++)
                body = {body, data_of(rand_byte())};
            for (k = 0; k < (cnt + 2) / 4; k++)
            begin
                codes = {codes, rand_byte()};
                body = {body, data_of(codes[k])};
            end
            for (v = 0; v < cnt - 1; v++)
                for (k = 0; k <= int'(codes[v / 4][2 * (v % 4) +: 2]); k++)
                    body = {body, data_of(rand_byte())};
        end
        // broken list, cut short
        if (forced == 0 && $urandom_range(0, 9) == 0)
        begin
            nb = $urandom_range(1, body.size() - 1);
            while (body.size() > nb)
                void'(body.pop_back());
        end
        foreach (body[i])
            send_item(body[i], quiet, 0, '0, '0);
    endtask

    task automatic send_noise();
        in_item_t it;
        int       n;
        if ($urandom_range(0, 1))
        begin
            it.req_type = REQ_START;
            it.way_flags = 16'($urandom);
            it.data_byte = rand_byte();
            send_item(it, 1'b0, 0, '0, '0);
        end
        n = $urandom_range(1, 10);
        repeat (n) send_item(data_of(rand_byte()), 1'b0, 0, '0, '0);
    endtask

    task automatic check_node(input out_item_t got);
        out_item_t want;
        n_checked++;
        if (pending_nodes.size() == 0)
        begin
            n_errors++;
            $display("%0t: unexpected node id %h pos %0d rep %b last %b", $time,
                     got.node_id, got.node_position, got.is_repeat, got.last_node);
            return;
        end
        want = pending_nodes.pop_front();
        if (got.node_id !== want.node_id)
        begin
            n_errors++;
            $display("%0t: node_id expected %h actual %h", $time, want.node_id, got.node_id);
        end
        if (got.node_position !== want.node_position)
        begin
            n_errors++;
            $display("%0t: node_position expected %0d actual %0d", $time,
                     want.node_position, got.node_position);
        end
        if (got.is_repeat !== want.is_repeat)
        begin
            n_errors++;
            $display("%0t: is_repeat expected %b actual %b", $time,
                     want.is_repeat, got.is_repeat);
        end
        if (got.last_node !== want.last_node)
        begin
            n_errors++;
            $display("%0t: last_node expected %b actual %b", $time,
                     want.last_node, got.last_node);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && node_out.valid === 1'b1 && node_out.ready === 1'b1)
            check_node(node_out.data);
    end

    // output side
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                node_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                n_holds++;
            end
            if ($urandom_range(0, 15) == 0)
                sink_quiet = !sink_quiet;
            stall = sink_quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                node_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            node_out.ready <= 1'b1;
            do
                @(negedge clk);
            while (node_out.valid !== 1'b1);
            @(posedge clk);
        end
    end

    initial
    begin
        in_item_t it;
        rst_n = 1'b0;
        byte_in.valid = 1'b0;
        byte_in.data = '0;
        node_out.ready = 1'b0;
        dec_phase = nlsd_pkg::PH_IDLE;
        list_flags = '0;
        node_idx = '0;
        word_acc = '0;
        byte_cnt = '0;
        prev_low = '0;
        first_id = '0;
        n_errors = 0;
        n_checked = 0;
        n_used = 0;
        n_lists = 0;
        n_holds = 0;
        cycle_cnt = 0;
        hold_req = 1'b0;
        sink_quiet = 1'b0;
        dir_rows = '{
            // byte with no list open, empty list
            '{REQ_DATA,  16'h1234, 8'hAB, 0, '0, '0},
            '{REQ_START, 16'h0000, 8'h00, 0, '0, '0},
            // raw single node, all ones
            '{REQ_START, 16'h0001, 8'hFF, 0, '0, '0},
            '{REQ_DATA,  16'hFFFF, 8'h0F, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'hFF, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'hFF, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'hFF, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'hFF, 1, '{35'h7_FFFF_FFFF, 11'd0, 1'b0, 1'b1}, '0},
            // byte after the list has ended
            '{REQ_DATA,  16'h0000, 8'h12, 0, '0, '0},
            // raw single node, all zeros
            '{REQ_START, 16'h0001, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 1, '{35'h0, 11'd0, 1'b0, 1'b1}, '0},
            // compressed closed uniform single node
            '{REQ_START, 16'hE001, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'hF3, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h34, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h12, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'h00, 2, '{35'h1_8000_0000, 11'd0, 1'b0, 1'b0},
                                             '{35'h1_8000_0000, 11'd1, 1'b1, 1'b1}},
            // full flag word, left open and abandoned by the next start
            '{REQ_START, 16'hFFFF, 8'h00, 0, '0, '0},
            '{REQ_DATA,  16'h0000, 8'hA5, 0, '0, '0}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            it.req_type = dir_rows[r].req;
            it.way_flags = dir_rows[r].flags;
            it.data_byte = dir_rows[r].dbyte;
            send_item(it, 1'b0, dir_rows[r].n_typed, dir_rows[r].t0, dir_rows[r].t1);
        end

        while (n_used < ITEMS)
        begin
            // input side waits for the output to drain
            if (n_lists == 4)
            begin
                byte_in.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_nodes.size() != 0);
            end
            if (n_lists == 8)
            begin
                hold_req = 1'b1;
                send_list(24, 1'b1);
            end
            else if ($urandom_range(0, 7) == 0)
                send_noise();
            else
                send_list(0, $urandom_range(0, 3) == 0);
            n_lists++;
        end

        byte_in.valid <= 1'b0;
        while (pending_nodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d decoded transactions over %0d table rows and %0d random lists",
                 n_used, $size(dir_rows), n_lists);
        $display("checked %0d nodes, %0d long output stall(s), %0d mismatches",
                 n_checked, n_holds, n_errors);
        if (n_errors == 0)
            $display("tb_node_list_stream_decoder_core passed");
        else
            $display("tb_node_list_stream_decoder_core failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/nlsd_pkg.sv
design/nlsd_stream_if.sv
design/node_list_stream_decoder_core.sv
tb/tb_node_list_stream_decoder_core.sv
